// File: design/tccw_pkg.sv
// Package with the constants, types and address helpers of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

  // Screen geometry.
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = ROWS * COLUMNS;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROW_SUM_W = ROW_W + 1;
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int ADDR_W    = $clog2(CELLS);

  // Port field widths.
  localparam int REQ_W      = 3;
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int CELL_W     = CHAR_W + COLOR_W;
  localparam int TROW_W     = 5;
  localparam int TCOL_W     = 7;
  localparam int ROW_OUT_W  = 5;
  localparam int COL_OUT_W  = 7;
  localparam int POS_OUT_W  = 11;

  // Character codes and the reset attribute.
  localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0]  CH_SPACE     = 8'h20;
  localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h0F;

  // Request codes; the codes above the last member are ignored requests.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUT        = 3'd0,
    REQ_PUT_OWN    = 3'd1,
    REQ_CLEAR      = 3'd2,
    REQ_SET_CURSOR = 3'd3,
    REQ_READ_CELL  = 3'd4
  } req_e;

  // One result as it leaves the block.
  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic [POS_OUT_W-1:0] pos;
    logic [CHAR_W-1:0]    cell_char;
    logic [COLOR_W-1:0]   cell_color;
  } res_t;

  // A blank cell: a space in the given attribute.
  function automatic logic [CELL_W-1:0] blank_cell(input logic [COLOR_W-1:0] color);
    return {color, CH_SPACE};
  endfunction

  // Clamp a requested row or column to the screen.
  function automatic logic [ROW_W-1:0] clamp_row(input logic [TROW_W-1:0] r);
    logic [ROW_W-1:0] res;
    if (32'(r) >= 32'(ROWS)) begin
      res = ROW_W'(ROWS - 1);
    end else begin
      res = ROW_W'(r);
    end
    return res;
  endfunction

  function automatic logic [COL_W-1:0] clamp_col(input logic [TCOL_W-1:0] c);
    logic [COL_W-1:0] res;
    if (32'(c) >= 32'(COLUMNS)) begin
      res = COL_W'(COLUMNS - 1);
    end else begin
      res = COL_W'(c);
    end
    return res;
  endfunction

  // Memory address of a screen cell. Rows are kept as a ring starting at top,
  // so a scroll only moves top and blanks one row.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] top,
                                                  input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ROW_SUM_W-1:0] sum;
    logic [ROW_W-1:0]     phys;
    sum = {1'b0, top} + {1'b0, row};
    if (sum >= ROW_SUM_W'(ROWS)) begin
      phys = ROW_W'(sum - ROW_SUM_W'(ROWS));
    end else begin
      phys = ROW_W'(sum);
    end
    return ADDR_W'(phys) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

  // Linear cursor position as seen by software.
  function automatic logic [ADDR_W-1:0] cursor_pos(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

// File: design/tccw_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read through a registered output; a read of the entry being
  // written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/text_console_char_writer_top.sv
// Top level of the text console writer: screen memory, cursor and request sequencer.
//
// Requests arrive on the input channel (in_valid_i / in_stall_o) and each one
// gives exactly one result on the output channel (out_valid_o / out_stall_i).
// The default attribute is written through the configuration channel
// (cfg_valid_i / cfg_ready_o), which is always ready.
// After acceptance each request is executed in ST_EXEC; the next request is taken only back in ST_IDLE:
//   put char, newline, set cursor, read cell, ignored codes: finish in ST_EXEC;
//   a put char or newline that scrolls: ST_SCROLL then blanks the COLUMNS cells of a row;
//   backspace from column 0 on a lower row: ST_WALK walks left over blanks, one cell at a time;
//   clear: ST_CLEAR then blanks all ROWS * COLUMNS cells.
// Scrolling only advances a ring pointer over the rows and blanks one row, so
// its cost is set by the single write port of the screen memory, as is clear.
// After reset the block runs a clearing pass over all ROWS * COLUMNS cells
// that fills the screen with spaces in the reset attribute; in_stall_o stays
// high meanwhile, configuration writes are taken as ever.
// A finished result waits in the output register while the receiver stalls;
// the next request is accepted meanwhile, and its result is held back until
// the output register is taken.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_writer_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration channel
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [tccw_pkg::COLOR_W-1:0]      cfg_text_color_i,
  // Request channel
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic [tccw_pkg::REQ_W-1:0]        req_type_i,
  input  wire logic [tccw_pkg::CHAR_W-1:0]       char_code_i,
  input  wire logic [tccw_pkg::COLOR_W-1:0]      char_color_i,
  input  wire logic [tccw_pkg::TROW_W-1:0]       target_row_i,
  input  wire logic [tccw_pkg::TCOL_W-1:0]       target_col_i,
  // Result channel
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic [tccw_pkg::ROW_OUT_W-1:0]    cursor_row_out_o,
  output      logic [tccw_pkg::COL_OUT_W-1:0]    cursor_col_out_o,
  output      logic [tccw_pkg::POS_OUT_W-1:0]    cursor_position_o,
  output      logic [tccw_pkg::CHAR_W-1:0]       cell_char_o,
  output      logic [tccw_pkg::COLOR_W-1:0]      cell_color_o
);

  import tccw_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_SCROLL,
    ST_CLEAR,
    ST_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    top_q, top_d;
  logic [ADDR_W-1:0]   cnt_q, cnt_d;
  logic [REQ_W-1:0]    req_q, req_d;
  logic [CHAR_W-1:0]   ch_q, ch_d;
  logic [COLOR_W-1:0]  act_color_q, act_color_d;
  logic [ROW_W-1:0]    trow_q, trow_d;
  logic [COL_W-1:0]    tcol_q, tcol_d;
  logic [CELL_W-1:0]   cell_q, cell_d;
  logic [COLOR_W-1:0]  text_color_q, text_color_d;
  logic                out_valid_q, out_valid_d;
  res_t                out_q, out_d;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  logic                finish;
  logic                out_free;
  logic                load_out;
  logic [ROW_W-1:0]    next_top;
  logic [ADDR_W-1:0]   res_pos;

  // Screen memory.
  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // Ring pointer after one scroll.
  assign next_top = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + ROW_W'(1);

  // Request sequencer.
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    top_d       = top_q;
    cnt_d       = cnt_q;
    req_d       = req_q;
    ch_d        = ch_q;
    act_color_d = act_color_q;
    trow_d      = trow_q;
    tcol_d      = tcol_q;
    cell_d      = (state_q == ST_DONE) ? cell_q : '0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = '0;
    finish      = 1'b0;

    case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = blank_cell(COLOR_RESET);
        if (cnt_q == ADDR_W'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        // The cell for a read request is fetched while the request is taken.
        ram_raddr = cell_addr(top_q, clamp_row(target_row_i), clamp_col(target_col_i));
        if (in_valid_i) begin
          req_d       = req_type_i;
          ch_d        = char_code_i;
          act_color_d = (req_type_i == REQ_PUT_OWN) ? char_color_i : text_color_q;
          trow_d      = clamp_row(target_row_i);
          tcol_d      = clamp_col(target_col_i);
          state_d     = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (req_q)
          REQ_PUT, REQ_PUT_OWN: begin
            if (ch_q == CH_NEWLINE) begin
              col_d = '0;
              if (row_q == ROW_W'(ROWS - 1)) begin
                top_d   = next_top;
                cnt_d   = '0;
                state_d = ST_SCROLL;
              end else begin
                row_d  = row_q + ROW_W'(1);
                finish = 1'b1;
              end
            end else if (ch_q == CH_BACKSPACE) begin
              if (col_q != '0) begin
                col_d     = col_q - COL_W'(1);
                ram_we    = 1'b1;
                ram_waddr = cell_addr(top_q, row_q, col_q - COL_W'(1));
                ram_wdata = blank_cell(act_color_q);
                finish    = 1'b1;
              end else if (row_q != '0) begin
                // Walk left from the end of the previous row over blanks.
                row_d     = row_q - ROW_W'(1);
                col_d     = COL_W'(COLUMNS - 1);
                ram_raddr = cell_addr(top_q, row_q - ROW_W'(1), COL_W'(COLUMNS - 1));
                state_d   = ST_WALK;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(top_q, row_q, col_q);
                ram_wdata = blank_cell(act_color_q);
                finish    = 1'b1;
              end
            end else begin
              ram_we    = 1'b1;
              ram_waddr = cell_addr(top_q, row_q, col_q);
              ram_wdata = {act_color_q, ch_q};
              if (col_q == COL_W'(COLUMNS - 1)) begin
                col_d = '0;
                if (row_q == ROW_W'(ROWS - 1)) begin
                  top_d   = next_top;
                  cnt_d   = '0;
                  state_d = ST_SCROLL;
                end else begin
                  row_d  = row_q + ROW_W'(1);
                  finish = 1'b1;
                end
              end else begin
                col_d  = col_q + COL_W'(1);
                finish = 1'b1;
              end
            end
          end
          REQ_CLEAR: begin
            row_d   = '0;
            col_d   = '0;
            cnt_d   = '0;
            state_d = ST_CLEAR;
          end
          REQ_SET_CURSOR: begin
            row_d  = trow_q;
            col_d  = tcol_q;
            finish = 1'b1;
          end
          REQ_READ_CELL: begin
            cell_d = ram_rdata;
            finish = 1'b1;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end

      ST_WALK: begin
        // The read data is the cell under the cursor, issued last cycle.
        if (col_q != '0 && ram_rdata == blank_cell(act_color_q)) begin
          col_d     = col_q - COL_W'(1);
          ram_raddr = cell_addr(top_q, row_q, col_q - COL_W'(1));
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cell_addr(top_q, row_q, col_q);
          ram_wdata = blank_cell(act_color_q);
          finish    = 1'b1;
        end
      end

      ST_SCROLL: begin
        // The ring has moved on; the old top row is now the bottom row.
        ram_we    = 1'b1;
        ram_waddr = cell_addr(top_q, ROW_W'(ROWS - 1), cnt_q[COL_W-1:0]);
        ram_wdata = blank_cell(act_color_q);
        if (cnt_q == ADDR_W'(COLUMNS - 1)) begin
          finish = 1'b1;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end

      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = blank_cell(text_color_q);
        if (cnt_q == ADDR_W'(CELLS - 1)) begin
          finish = 1'b1;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end

      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (finish) begin
      state_d = out_free ? ST_IDLE : ST_DONE;
    end
  end

  // Result formatting from the cursor after the request.
  assign load_out = (finish || state_q == ST_DONE) && out_free;
  assign res_pos  = cursor_pos(row_d, col_d);

  always_comb begin
    out_d            = out_q;
    out_d.row        = ROW_OUT_W'(row_d);
    out_d.col        = COL_OUT_W'(col_d);
    out_d.pos        = POS_OUT_W'(res_pos);
    out_d.cell_char  = cell_d[CHAR_W-1:0];
    out_d.cell_color = cell_d[CELL_W-1:CHAR_W];
    if (!load_out) begin
      out_d = out_q;
    end
    out_valid_d = out_free ? load_out : 1'b1;
  end

  // Default attribute register.
  always_comb begin
    text_color_d = text_color_q;
    if (cfg_valid_i && cfg_ready_o) begin
      text_color_d = cfg_text_color_i;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      row_q        <= '0;
      col_q        <= '0;
      top_q        <= '0;
      cnt_q        <= '0;
      req_q        <= '0;
      ch_q         <= '0;
      act_color_q  <= '0;
      trow_q       <= '0;
      tcol_q       <= '0;
      cell_q       <= '0;
      text_color_q <= COLOR_RESET;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      row_q        <= row_d;
      col_q        <= col_d;
      top_q        <= top_d;
      cnt_q        <= cnt_d;
      req_q        <= req_d;
      ch_q         <= ch_d;
      act_color_q  <= act_color_d;
      trow_q       <= trow_d;
      tcol_q       <= tcol_d;
      cell_q       <= cell_d;
      text_color_q <= text_color_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  // Port drive.
  assign cfg_ready_o       = 1'b1;
  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign cursor_row_out_o  = out_q.row;
  assign cursor_col_out_o  = out_q.col;
  assign cursor_position_o = out_q.pos;
  assign cell_char_o       = out_q.cell_char;
  assign cell_color_o      = out_q.cell_color;

  // An accepted request is executed in the following cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_EXEC)
    else $error("accepted request was not executed in the next cycle");

  // The screen memory is never written while the block waits for a request.
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE || state_q == ST_DONE |-> !ram_we)
    else $error("screen memory written while idle");

  // The cursor stays on the screen.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) < 32'(ROWS) && 32'(col_q) < 32'(COLUMNS))
    else $error("cursor left the screen");

  // While the bottom row is blanked after a scroll the cursor sits on it.
  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCROLL |-> row_q == ROW_W'(ROWS - 1) && col_q == '0)
    else $error("scroll with the cursor off the bottom row");

  // A new result is only loaded when the previous one has been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !load_out)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// File: tb/sv/text_console_char_writer_checker.sv
// Checker for the text console writer: keeps its own screen and cursor and compares results.
`timescale 1ns / 1ps

module text_console_char_writer_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [tccw_pkg::COLOR_W-1:0]   cfg_text_color_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [tccw_pkg::REQ_W-1:0]     req_type_i,
  input  logic [tccw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tccw_pkg::COLOR_W-1:0]   char_color_i,
  input  logic [tccw_pkg::TROW_W-1:0]    target_row_i,
  input  logic [tccw_pkg::TCOL_W-1:0]    target_col_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [tccw_pkg::ROW_OUT_W-1:0] cursor_row_out_i,
  input  logic [tccw_pkg::COL_OUT_W-1:0] cursor_col_out_i,
  input  logic [tccw_pkg::POS_OUT_W-1:0] cursor_position_i,
  input  logic [tccw_pkg::CHAR_W-1:0]    cell_char_i,
  input  logic [tccw_pkg::COLOR_W-1:0]   cell_color_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o,
  output int                             scrolls_o,
  output int                             walks_o
);

  import tccw_pkg::*;

  // Shadow copy of the screen, the cursor and the default attribute.
  logic [CELL_W-1:0]  screen_mem [CELLS];
  int                 cur_row;
  int                 cur_col;
  logic [COLOR_W-1:0] attr_default;
  res_t               expected_q [$];

  function automatic int cell_at(input int row, input int col);
    return row * COLUMNS + col;
  endfunction

  // Effect of one character written with the attribute of its request.
  function automatic void apply_char(input logic [CHAR_W-1:0] ch,
                                     input logic [COLOR_W-1:0] attr);
    logic [CELL_W-1:0] blank;
    blank = {attr, CH_SPACE};
    if (ch == CH_NEWLINE) begin
      cur_row++;
      cur_col = 0;
    end else if (ch == CH_BACKSPACE) begin
      if (cur_col > 0) begin
        cur_col--;
      end else if (cur_row > 0) begin
        // Back onto the previous row, then walk left over blanks.
        cur_row--;
        cur_col = COLUMNS - 1;
        walks_o++;
        while (cur_col > 0 && screen_mem[cell_at(cur_row, cur_col)] == blank) begin
          cur_col--;
        end
      end
      screen_mem[cell_at(cur_row, cur_col)] = blank;
    end else begin
      screen_mem[cell_at(cur_row, cur_col)] = {attr, ch};
      cur_col++;
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
      end
    end
    // Running off the bottom moves every row up and blanks the last one.
    if (cur_row >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
        screen_mem[i] = screen_mem[i + COLUMNS];
      end
      for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) begin
        screen_mem[i] = blank;
      end
      cur_row = ROWS - 1;
      scrolls_o++;
    end
  endfunction

  // Updates the shadow state for one request and returns its expected result.
  function automatic res_t console_result(input logic [REQ_W-1:0]   req,
                                          input logic [CHAR_W-1:0]  ch,
                                          input logic [COLOR_W-1:0] own_attr,
                                          input logic [TROW_W-1:0]  trow,
                                          input logic [TCOL_W-1:0]  tcol);
    res_t              res;
    int                rd_row;
    int                rd_col;
    logic [CELL_W-1:0] rd_cell;
    res    = '0;
    rd_row = (int'(trow) >= ROWS) ? ROWS - 1 : int'(trow);
    rd_col = (int'(tcol) >= COLUMNS) ? COLUMNS - 1 : int'(tcol);
    case (req)
      REQ_PUT: begin
        apply_char(ch, attr_default);
      end
      REQ_PUT_OWN: begin
        apply_char(ch, own_attr);
      end
      REQ_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          screen_mem[i] = {attr_default, CH_SPACE};
        end
        cur_row = 0;
        cur_col = 0;
      end
      REQ_SET_CURSOR: begin
        cur_row = rd_row;
        cur_col = rd_col;
      end
      REQ_READ_CELL: begin
        rd_cell        = screen_mem[cell_at(rd_row, rd_col)];
        res.cell_char  = rd_cell[CHAR_W-1:0];
        res.cell_color = rd_cell[CELL_W-1:CHAR_W];
      end
      default: begin
      end
    endcase
    res.row = ROW_OUT_W'(cur_row);
    res.col = COL_OUT_W'(cur_col);
    res.pos = POS_OUT_W'(cell_at(cur_row, cur_col));
    return res;
  endfunction

  // Results are checked before new requests are predicted, so a transaction can
  // never be matched against a prediction made at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) begin
        screen_mem[i] = {COLOR_RESET, CH_SPACE};
      end
      cur_row      = 0;
      cur_col      = 0;
      attr_default = COLOR_RESET;
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      scrolls_o    = 0;
      walks_o      = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{cursor_row_out_i, cursor_col_out_i, cursor_position_i,
                cell_char_i, cell_color_i};
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("Unexpected result with no request outstanding: row %0d col %0d",
                     got.row, got.col);
          end
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          if (got.row !== want.row || got.col !== want.col || got.pos !== want.pos ||
              got.cell_char !== want.cell_char || got.cell_color !== want.cell_color) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("Mismatch on result %0d: expected row %0d col %0d pos %0d %02h/%02h",
                       checked_o, want.row, want.col, want.pos, want.cell_char,
                       want.cell_color);
              $display("                          got row %0d col %0d pos %0d %02h/%02h",
                       got.row, got.col, got.pos, got.cell_char, got.cell_color);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(console_result(req_type_i, char_code_i, char_color_i,
                                            target_row_i, target_col_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        attr_default = cfg_text_color_i;
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// File: tb/sv/text_console_char_writer_top_tb.sv
// Testbench top for the text console writer: stimulus, flow control and the verdict.
`timescale 1ns / 1ps

module text_console_char_writer_top_tb;
  import tccw_pkg::*;

  // Request codes above the last defined one are ignored by the block.
  localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = 3'd7;

  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 300;
  localparam int HOLD_CYCLES    = 400;
  // Longest legal quiet spell is a clear or the clearing pass after reset,
  // plus a long receiver hold-off; this leaves ample margin.
  localparam int WATCHDOG_LIMIT = 25000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [COLOR_W-1:0]   cfg_text_color_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [REQ_W-1:0]     req_type_i;
  logic [CHAR_W-1:0]    char_code_i;
  logic [COLOR_W-1:0]   char_color_i;
  logic [TROW_W-1:0]    target_row_i;
  logic [TCOL_W-1:0]    target_col_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [ROW_OUT_W-1:0] cursor_row_out_o;
  logic [COL_OUT_W-1:0] cursor_col_out_o;
  logic [POS_OUT_W-1:0] cursor_position_o;
  logic [CHAR_W-1:0]    cell_char_o;
  logic [COLOR_W-1:0]   cell_color_o;

  int fail_count;
  int pending;
  int checked;
  int scrolls;
  int walks;

  bit                 send_gaps;
  bit                 recv_gaps;
  bit                 hold_off_req;
  logic [COLOR_W-1:0] cur_attr;
  int                 n_chars;
  int                 n_newlines;
  int                 n_backspaces;
  int                 n_clears;
  int                 n_moves;
  int                 n_reads;
  int                 n_unused;
  int                 n_colours;

  text_console_char_writer_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_text_color_i  (cfg_text_color_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .char_code_i       (char_code_i),
    .char_color_i      (char_color_i),
    .target_row_i      (target_row_i),
    .target_col_i      (target_col_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cursor_row_out_o  (cursor_row_out_o),
    .cursor_col_out_o  (cursor_col_out_o),
    .cursor_position_o (cursor_position_o),
    .cell_char_o       (cell_char_o),
    .cell_color_o      (cell_color_o)
  );

  text_console_char_writer_checker checker_inst (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_text_color_i  (cfg_text_color_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .req_type_i        (req_type_i),
    .char_code_i       (char_code_i),
    .char_color_i      (char_color_i),
    .target_row_i      (target_row_i),
    .target_col_i      (target_col_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cursor_row_out_i  (cursor_row_out_o),
    .cursor_col_out_i  (cursor_col_out_o),
    .cursor_position_i (cursor_position_o),
    .cell_char_i       (cell_char_o),
    .cell_color_i      (cell_color_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .checked_o         (checked),
    .scrolls_o         (scrolls),
    .walks_o           (walks)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, or a long hold-off counted here when requested.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= recv_gaps && ($urandom_range(99) < 11);
      end
    end
  end

  // Watchdog on cycles in which no transaction of any kind completes.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Offers one request, after an optional random gap, and holds it until taken.
  task automatic send_request(input logic [REQ_W-1:0]   req,
                              input logic [CHAR_W-1:0]  ch,
                              input logic [COLOR_W-1:0] attr,
                              input logic [TROW_W-1:0]  trow,
                              input logic [TCOL_W-1:0]  tcol);
    @(negedge clk_i);
    while (send_gaps && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    char_code_i  <= ch;
    char_color_i <= attr;
    target_row_i <= trow;
    target_col_i <= tcol;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    case (req)
      REQ_PUT, REQ_PUT_OWN: begin
        if (ch == CH_NEWLINE) n_newlines++;
        else if (ch == CH_BACKSPACE) n_backspaces++;
        else n_chars++;
      end
      REQ_CLEAR:      n_clears++;
      REQ_SET_CURSOR: n_moves++;
      REQ_READ_CELL:  n_reads++;
      default:        n_unused++;
    endcase
  endtask

  // Drops the request channel and waits until every result has been taken.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the default attribute; only called with the block idle.
  task automatic write_text_color(input logic [COLOR_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i      <= 1'b1;
    cfg_text_color_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_attr = value;
    n_colours++;
  endtask

  // Main stimulus.
  initial begin
    logic [REQ_W-1:0]   req;
    logic [CHAR_W-1:0]  ch;
    logic [COLOR_W-1:0] attr;
    logic [TROW_W-1:0]  trow;
    logic [TCOL_W-1:0]  tcol;
    int                 pick;

    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_text_color_i = '0;
    in_valid_i       = 1'b0;
    req_type_i       = '0;
    char_code_i      = '0;
    char_color_i     = '0;
    target_row_i     = '0;
    target_col_i     = '0;
    send_gaps        = 1'b1;
    recv_gaps        = 1'b1;
    hold_off_req     = 1'b0;
    cur_attr         = COLOR_RESET;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: reset contents, clamping, colour extremes, wrap and
    // scroll on the last row, backspace walks and the origin, unused codes.
    send_request(REQ_READ_CELL, 8'h00, 8'h00, 5'd0, 7'd0);
    send_request(REQ_READ_CELL, 8'h00, 8'h00, 5'd31, 7'd127);
    send_request(REQ_PUT, 8'h00, 8'h00, 5'd0, 7'd0);
    send_request(REQ_PUT_OWN, 8'hFF, 8'hFF, 5'd0, 7'd0);
    send_request(REQ_PUT_OWN, 8'h42, 8'h00, 5'd0, 7'd0);
    send_request(REQ_PUT, CH_SPACE, 8'h00, 5'd0, 7'd0);
    send_request(REQ_PUT, CH_BACKSPACE, 8'h00, 5'd0, 7'd0);
    send_request(REQ_READ_CELL, 8'h00, 8'h00, 5'd0, 7'd1);
    send_request(REQ_SET_CURSOR, 8'h00, 8'h00, 5'd0, 7'd0);
    send_request(REQ_PUT, CH_BACKSPACE, 8'h00, 5'd0, 7'd0);
    send_request(REQ_SET_CURSOR, 8'h00, 8'h00, 5'd31, 7'd127);
    send_request(REQ_PUT, 8'h5A, 8'h00, 5'd0, 7'd0);
    send_request(REQ_PUT, CH_NEWLINE, 8'h00, 5'd0, 7'd0);
    send_request(REQ_PUT, CH_BACKSPACE, 8'h00, 5'd0, 7'd0);
    send_request(REQ_PUT, CH_BACKSPACE, 8'h00, 5'd0, 7'd0);
    send_request(REQ_READ_CELL, 8'h00, 8'h00, 5'd22, 7'd79);
    send_request(REQ_SET_CURSOR, 8'h00, 8'h00, 5'd12, 7'd40);
    send_request(REQ_PUT_OWN, CH_NEWLINE, 8'hA5, 5'd12, 7'd40);
    send_request(REQ_UNUSED_FIRST, 8'hFF, 8'hFF, 5'd31, 7'd127);
    send_request(REQ_UNUSED_FIRST + 3'd1, 8'hFF, 8'hFF, 5'd31, 7'd127);
    send_request(REQ_UNUSED_LAST, 8'hFF, 8'hFF, 5'd31, 7'd127);
    send_request(REQ_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0);
    send_request(REQ_READ_CELL, 8'h00, 8'h00, 5'd24, 7'd79);
    send_request(REQ_SET_CURSOR, 8'h00, 8'h00, 5'd25, 7'd80);

    // Random phases, each under its own default attribute.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      if (phase == 0) write_text_color(8'h00);
      else if (phase == 1) write_text_color(8'hFF);
      else write_text_color(COLOR_W'($urandom_range(255)));
      // One long stretch with no idling on either side.
      send_gaps = (phase != 2);
      recv_gaps = (phase != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Receiver holds off while the sender keeps offering back to back.
        if (phase == 1 && n == 150) begin
          hold_off_req = 1'b1;
          send_gaps    = 1'b0;
        end
        if (phase == 1 && n == 260) send_gaps = 1'b1;
        // Sender pauses until every outstanding result is back.
        if (phase == 3 && n == 120) drain();

        req  = REQ_PUT;
        ch   = CHAR_W'($urandom_range(255));
        attr = COLOR_W'($urandom_range(255));
        trow = TROW_W'($urandom_range(31));
        tcol = TCOL_W'($urandom_range(127));
        pick = $urandom_range(999);
        if (pick < 5) begin
          req = REQ_CLEAR;
        end else if (pick < 25) begin
          req = REQ_GEN_UNUSED();
        end else if (pick < 145) begin
          req = (pick < 65) ? REQ_SET_CURSOR : REQ_READ_CELL;
          // Mostly on screen, with column 0 favoured to set up walks.
          if ($urandom_range(99) < 80) begin
            trow = TROW_W'($urandom_range(ROWS - 1));
            tcol = ($urandom_range(99) < 30) ? '0 : TCOL_W'($urandom_range(COLUMNS - 1));
          end
        end else begin
          req  = ($urandom_range(99) < 60) ? REQ_PUT : REQ_PUT_OWN;
          pick = $urandom_range(99);
          if (pick < 9) ch = CH_NEWLINE;
          else if (pick < 20) ch = CH_BACKSPACE;
          else if (pick < 35) ch = CH_SPACE;
          // Own colour often equals the default so blanks match in walks.
          if ($urandom_range(99) < 50) attr = cur_attr;
        end
        send_request(req, ch, attr, trow, tcol);
      end
    end
    drain();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d characters, %0d newlines, %0d backspaces, %0d clears,",
             n_chars, n_newlines, n_backspaces, n_clears);
    $display("  %0d moves, %0d reads and %0d unused codes; checked %0d results",
             n_moves, n_reads, n_unused, checked);
    $display("  over %0d scrolls, %0d backspace walks and %0d colour settings",
             scrolls, walks, n_colours);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Picks one of the codes the block ignores.
  function automatic logic [REQ_W-1:0] REQ_GEN_UNUSED();
    return REQ_W'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
  endfunction

endmodule
